FILE: design/key_dedup_keep_max_table_core_macros.svh
// Assertion macros for the key dedup table core checker
`ifndef KEY_DEDUP_KEEP_MAX_TABLE_CORE_MACROS_SVH
`define KEY_DEDUP_KEEP_MAX_TABLE_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset
`define KD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define KD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/kdkm_pkg.sv
// Shared types and codes for the key dedup table core
package kdkm_pkg;
    localparam int PC_BITS   = 64;
    localparam int FILE_BITS = 16;
    localparam int ROW_BITS  = 32;
    localparam int CNT_BITS  = 17;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_DRAIN = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_LOSER    = 2'd1,
        KIND_FULL     = 2'd2,
        KIND_BAD_FILE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key;
        logic [63:0] precombine;
        logic        is_deleted;
        logic [15:0] file_index;
        logic [31:0] row_index;
        logic [5:0]  slot;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] loser_file;
        logic [31:0] loser_row;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // load the incoming item
        logic search;    // register match and free results
        logic execute;   // update table and build result
    } kdkm_cmd_t;
endpackage

FILE: design/kdkm_datapath.sv
// Table storage, key search and result building
module kdkm_datapath #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kdkm_pkg::kdkm_cmd_t  cmd,
    input  kdkm_pkg::in_item_t   item,
    input  logic [16:0]          file_count,
    output kdkm_pkg::out_item_t  result
);
    import kdkm_pkg::*;
    localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [KEY_BITS-1:0]    key_mem  [TABLE_DEPTH];
    logic [PC_BITS-1:0]     pc_mem   [TABLE_DEPTH];
    logic [FILE_BITS-1:0]   file_mem [TABLE_DEPTH];
    logic [ROW_BITS-1:0]    row_mem  [TABLE_DEPTH];
    logic                   del_mem  [TABLE_DEPTH];

    in_item_t               item_reg;
    logic                   hit_reg, free_found_reg, bad_file_reg;
    logic [IDX_BITS-1:0]    hit_idx_reg, free_idx_reg;
    logic [PC_BITS-1:0]     hit_pc_reg;
    logic [FILE_BITS-1:0]   hit_file_reg;
    logic [ROW_BITS-1:0]    hit_row_reg;
    logic                   drain_ok_reg;
    logic [FILE_BITS-1:0]   drain_file_reg;
    logic [ROW_BITS-1:0]    drain_row_reg;
    out_item_t              result_reg;
    out_item_t              result_next;

    logic [TABLE_DEPTH-1:0] match;
    logic                   hit_next, free_next;
    logic [IDX_BITS-1:0]    hit_idx_next, free_idx_next;
    logic [IDX_BITS-1:0]    slot_idx;
    logic                   slot_in_range;

    // parallel compare and first-match / first-free encode
    always_comb
    begin
        hit_next = 1'b0;
        free_next = 1'b0;
        hit_idx_next = '0;
        free_idx_next = '0;
        for (int s = 0; s < TABLE_DEPTH; s++)
        begin
            match[s] = valid_reg[s] && (key_mem[s] == item_reg.key[KEY_BITS-1:0]);
        end
        for (int s = TABLE_DEPTH - 1; s >= 0; s--)
        begin
            if (match[s])
            begin
                hit_next = 1'b1;
                hit_idx_next = IDX_BITS'(s);
            end
            if (!valid_reg[s])
            begin
                free_next = 1'b1;
                free_idx_next = IDX_BITS'(s);
            end
        end
    end

    assign slot_idx = IDX_BITS'(item_reg.slot);
    assign slot_in_range = ({26'd0, item_reg.slot} < 32'(TABLE_DEPTH));

    // item capture and search stage
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= item;
        if (cmd.search)
        begin
            hit_reg        <= hit_next;
            hit_idx_reg    <= hit_idx_next;
            free_found_reg <= free_next;
            free_idx_reg   <= free_idx_next;
            bad_file_reg   <= ({1'b0, item_reg.file_index} >= file_count);
            hit_pc_reg     <= pc_mem[hit_idx_next];
            hit_file_reg   <= file_mem[hit_idx_next];
            hit_row_reg    <= row_mem[hit_idx_next];
            drain_ok_reg   <= slot_in_range && valid_reg[slot_idx] && del_mem[slot_idx];
            drain_file_reg <= file_mem[slot_idx];
            drain_row_reg  <= row_mem[slot_idx];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.execute)
        begin
            if (item_reg.op == OP_CLEAR)
                valid_reg <= '0;
            else if (item_reg.op == OP_ADD && !bad_file_reg && !hit_reg && free_found_reg)
                valid_reg[free_idx_reg] <= 1'b1;
        end
    end

    // result of the item under execution
    always_comb
    begin
        result_next = '0;
        unique case (op_t'(item_reg.op))
            OP_ADD:
            begin
                if (bad_file_reg)
                    result_next.kind = KIND_BAD_FILE;
                else if (hit_reg)
                begin
                    result_next.kind = KIND_LOSER;
                    if (item_reg.precombine > hit_pc_reg)
                    begin
                        result_next.loser_file = hit_file_reg;
                        result_next.loser_row  = hit_row_reg;
                    end
                    else
                    begin
                        result_next.loser_file = item_reg.file_index;
                        result_next.loser_row  = item_reg.row_index;
                    end
                end
                else if (!free_found_reg)
                    result_next.kind = KIND_FULL;
            end
            OP_DRAIN:
            begin
                if (drain_ok_reg)
                begin
                    result_next.kind       = KIND_LOSER;
                    result_next.loser_file = drain_file_reg;
                    result_next.loser_row  = drain_row_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // table write and result register
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            result_reg <= result_next;
            if (item_reg.op == OP_ADD && !bad_file_reg)
            begin
                if (hit_reg)
                begin
                    if (item_reg.precombine > hit_pc_reg)
                    begin
                        key_mem[hit_idx_reg]  <= item_reg.key[KEY_BITS-1:0];
                        pc_mem[hit_idx_reg]   <= item_reg.precombine;
                        file_mem[hit_idx_reg] <= item_reg.file_index;
                        row_mem[hit_idx_reg]  <= item_reg.row_index;
                        del_mem[hit_idx_reg]  <= item_reg.is_deleted;
                    end
                end
                else if (free_found_reg)
                begin
                    key_mem[free_idx_reg]  <= item_reg.key[KEY_BITS-1:0];
                    pc_mem[free_idx_reg]   <= item_reg.precombine;
                    file_mem[free_idx_reg] <= item_reg.file_index;
                    row_mem[free_idx_reg]  <= item_reg.row_index;
                    del_mem[free_idx_reg]  <= item_reg.is_deleted;
                end
            end
        end
    end

    assign result = result_reg;
endmodule

FILE: design/kdkm_ctrl.sv
// Sequencing controller and output handshake
module kdkm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output kdkm_pkg::kdkm_cmd_t cmd
);
    import kdkm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EXEC,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.capture = (state_reg == ST_IDLE) && in_valid;
    assign cmd.search  = (state_reg == ST_SEARCH);
    assign cmd.execute = (state_reg == ST_EXEC);

    // state and registered output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:   if (in_valid) state_reg <= ST_SEARCH;
                ST_SEARCH: state_reg <= ST_EXEC;
                ST_EXEC:
                begin
                    state_reg     <= ST_OUT;
                    out_valid_reg <= 1'b1;
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b0;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: design/key_dedup_keep_max_table_core.sv
// Top level of the key dedup keep-max table core
// An input transfer passes through the capture, search and update steps before its result is valid.
// Only one item is in flight: a new item is accepted only after the previous result is taken, since
// the single-item sequencer and the registered table search handle one item at a time.
// Reset: asynchronous active low; all slots empty, file_count = 1.
module key_dedup_keep_max_table_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  kdkm_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output kdkm_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [16:0]         cfg_data
);
    import kdkm_pkg::*;

    kdkm_cmd_t   cmd;
    logic [16:0] file_count_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            file_count_reg <= 17'd1;
        else if (cfg_we)
            file_count_reg <= cfg_data;
    end

    kdkm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    kdkm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .item       (in_data),
        .file_count (file_count_reg),
        .result     (out_data)
    );
endmodule

FILE: design/kdkm_checker.sv
// Port-level checker for the key dedup table core, with its bind
`include "key_dedup_keep_max_table_core_macros.svh"
module kdkm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input kdkm_pkg::out_item_t out_data
);
    import kdkm_pkg::*;

    `KD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
    `KD_ASSERT_IMPL(a_one_in_flight, clk, rst_n, out_valid, in_stall, "input taken while result pending")
    `KD_ASSERT_NEXT(a_no_dup, clk, rst_n, out_valid && !out_stall, !out_valid, "result repeated")
    `KD_ASSERT_IMPL(a_zero_fields, clk, rst_n, out_valid && out_data.kind != KIND_LOSER, out_data.loser_file == 16'd0 && out_data.loser_row == 32'd0, "loser fields set without loser")
endmodule

bind key_dedup_keep_max_table_core kdkm_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
